FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/rrts_pkg.sv
package rrts_pkg;

  localparam int ThreadW       = 6;
  localparam int MaskW         = 32;
  localparam int MaskIdxW      = $clog2(MaskW);
  localparam int TicksW        = 32;
  localparam int OpW           = 2;
  localparam int DefMaxThreads = 32;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_DELAY = 2'd1,
    OP_SCHED = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCHED,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler with per-thread sleep counters.
// Request channel: opcode_i and delay_ticks_i are taken at a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// Result channel: result_valid_o is high for exactly one cycle, together with
// next_thread_o, switch_request_o, ready_mask_o and error_o. The receiver
// cannot stall it; a result not taken in that cycle is gone.
// Configuration: cfg_data_i (thread count) is written when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o is high only while idle with start
// low. A write re-registers all threads: ready bits set, sleep counters cleared.
// Request handling, with n the effective thread count:
//   tick     : one sleep counter per cycle through the shared decrementer,
//              threads 1 to n - 1 in turn, then the result cycle
//   schedule : one candidate thread tested per cycle, from the thread after
//              the current one; the idle thread, with no search, when none is ready
//   delay    : as schedule; from the idle thread, straight to an error result
//   opcode 3 : straight to the result
// A new request is taken the cycle after the result, so at most one request
// is in flight. Reset: thread count 1, no ready threads, counters zero,
// current thread idle, no thread run yet.
`include "assert_macros.svh"

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::DefMaxThreads
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrts_pkg::OpW-1:0]      opcode_i,
  input  logic [rrts_pkg::TicksW-1:0]   delay_ticks_i,
  output logic                          result_valid_o,
  output logic [rrts_pkg::ThreadW-1:0]  next_thread_o,
  output logic                          switch_request_o,
  output logic [rrts_pkg::MaskW-1:0]    ready_mask_o,
  output logic                          error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrts_pkg::ThreadW-1:0]  cfg_data_i
);

  import rrts_pkg::*;

  localparam int IdxW = $clog2(MAX_THREADS);
  localparam logic [ThreadW-1:0] MaxCount = ThreadW'(MAX_THREADS + 1);
  localparam logic [ThreadW-1:0] One      = ThreadW'(1);

  function automatic logic [ThreadW-1:0] eff_count(input logic [ThreadW-1:0] v);
    logic [ThreadW-1:0] r;
    r = v;
    if (v == '0) r = One;
    if (v > MaxCount) r = MaxCount;
    return r;
  endfunction

  function automatic logic [MaskW-1:0] valid_mask(input logic [ThreadW-1:0] n);
    logic [ThreadW-1:0] users;
    users = n - One;
    if (users >= ThreadW'(MaskW)) return '1;
    return (MaskW'(1) << users) - MaskW'(1);
  endfunction

  state_e             state_q, state_d;
  logic [ThreadW-1:0] count_q, count_d;
  logic [MaskW-1:0]   ready_q, ready_d;
  logic [ThreadW-1:0] cur_q, cur_d;
  logic               has_run_q, has_run_d;
  logic [ThreadW-1:0] walk_q, walk_d;
  logic               sw_q, sw_d;
  logic               err_q, err_d;
  logic [TicksW-1:0]  sleep_q [MAX_THREADS];

  logic               sleep_we;
  logic               sleep_clr;
  logic [IdxW-1:0]    sleep_wa;
  logic [TicksW-1:0]  sleep_wd;
  logic [TicksW-1:0]  sleep_rd;
  logic [TicksW-1:0]  dec;

  logic               accept;
  logic               cfg_fire;
  op_e                op;
  logic [ThreadW-1:0] n_eff;
  logic [ThreadW-1:0] walk_m1;
  logic [ThreadW-1:0] cur_m1;
  logic [ThreadW-1:0] walk_p1;
  logic [ThreadW-1:0] cand;
  logic [ThreadW-1:0] cand_m1;
  logic               found;
  logic [ThreadW-1:0] pick;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign accept      = start && !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign op          = op_e'(opcode_i);
  assign n_eff       = eff_count(count_q);

  assign walk_m1  = walk_q - One;
  assign cur_m1   = cur_q - One;
  assign walk_p1  = walk_q + One;
  assign cand     = (walk_p1 >= n_eff) ? One : walk_p1;
  assign cand_m1  = cand - One;
  assign sleep_rd = sleep_q[walk_m1[IdxW-1:0]];
  assign dec      = sleep_rd - TicksW'(1);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    if (ready_q == '0) begin
      found = 1'b1;
    end else if (ready_q[cand_m1[MaskIdxW-1:0]]) begin
      found = 1'b1;
      pick  = cand;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!cfg_fire && accept) begin
          case (op)
            OP_TICK:  state_d = (n_eff > One) ? ST_TICK : ST_DONE;
            OP_DELAY: state_d = (cur_q != '0) ? ST_SCHED : ST_DONE;
            OP_SCHED: state_d = ST_SCHED;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK:  state_d = (walk_p1 >= n_eff) ? ST_DONE : ST_TICK;
      ST_SCHED: state_d = found ? ST_DONE : ST_SCHED;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    ready_d   = ready_q;
    cur_d     = cur_q;
    has_run_d = has_run_q;
    walk_d    = walk_q;
    sw_d      = sw_q;
    err_d     = err_q;
    sleep_we  = 1'b0;
    sleep_clr = 1'b0;
    sleep_wa  = walk_m1[IdxW-1:0];
    sleep_wd  = dec;
    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          count_d   = cfg_data_i;
          ready_d   = valid_mask(eff_count(cfg_data_i));
          cur_d     = '0;
          has_run_d = 1'b0;
          sleep_clr = 1'b1;
        end else if (accept) begin
          sw_d   = 1'b0;
          err_d  = 1'b0;
          walk_d = cur_q;
          case (op)
            OP_TICK: walk_d = One;
            OP_DELAY: begin
              if (cur_q == '0) begin
                err_d = 1'b1;
              end else begin
                sleep_we                      = 1'b1;
                sleep_wa                      = cur_m1[IdxW-1:0];
                sleep_wd                      = delay_ticks_i;
                ready_d[cur_m1[MaskIdxW-1:0]] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (sleep_rd != '0) begin
          sleep_we = 1'b1;
          if (dec == '0) ready_d[walk_m1[MaskIdxW-1:0]] = 1'b1;
        end
        walk_d = walk_p1;
      end
      ST_SCHED: begin
        if (found) begin
          sw_d      = (pick != cur_q) || !has_run_q;
          cur_d     = pick;
          has_run_d = 1'b1;
        end else begin
          walk_d = cand;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= One;
      ready_q   <= '0;
      cur_q     <= '0;
      has_run_q <= 1'b0;
      walk_q    <= '0;
      sw_q      <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ready_q   <= ready_d;
      cur_q     <= cur_d;
      has_run_q <= has_run_d;
      walk_q    <= walk_d;
      sw_q      <= sw_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) sleep_q[i] <= '0;
    end else if (sleep_clr) begin
      for (int i = 0; i < MAX_THREADS; i++) sleep_q[i] <= '0;
    end else if (sleep_we) begin
      sleep_q[sleep_wa] <= sleep_wd;
    end
  end

  assign result_valid_o   = (state_q == ST_DONE);
  assign next_thread_o    = cur_q;
  assign switch_request_o = sw_q;
  assign ready_mask_o     = ready_q;
  assign error_o          = err_q;

  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_IMP(a_thread_in_range, clk_i, rst_ni, result_valid_o, next_thread_o < n_eff)
  `ASSERT_IMP(a_ready_subset, clk_i, rst_ni, 1'b1, (ready_q & ~valid_mask(n_eff)) == '0)
  `ASSERT_IMP(a_error_no_switch, clk_i, rst_ni, result_valid_o && error_o, !switch_request_o)

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int MaxThreads = DefMaxThreads;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [ThreadW-1:0] thread;
    logic               switch_req;
    logic [MaskW-1:0]   mask;
    logic               err;
  } pick_t;

  class schedule_tracker;
    logic [ThreadW-1:0] thread_total;
    logic [MaskW-1:0]   ready_now;
    logic [TicksW-1:0]  sleep_left [MaxThreads];
    int unsigned        running;
    bit                 has_run_any;
    pick_t              pending_picks[$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      set_thread_total(ThreadW'(1));
    endfunction

    function int unsigned live_threads();
      int unsigned n;
      n = thread_total;
      if (n < 1) n = 1;
      if (n > MaxThreads + 1) n = MaxThreads + 1;
      return n;
    endfunction

    function logic [MaskW-1:0] user_mask();
      int unsigned users;
      users = live_threads() - 1;
      if (users >= MaskW) return '1;
      return MaskW'((64'd1 << users) - 64'd1);
    endfunction

    function void set_thread_total(logic [ThreadW-1:0] value);
      thread_total = value;
      ready_now = user_mask();
      foreach (sleep_left[i]) sleep_left[i] = '0;
      running = 0;
      has_run_any = 0;
    endfunction

    function int unsigned pick_next();
      int unsigned n;
      int unsigned idx;
      n = live_threads();
      idx = running;
      if ((ready_now & user_mask()) == '0) return 0;
      for (int g = 0; g <= MaxThreads + 1; g++) begin
        idx++;
        if (idx >= n) idx = 1;
        if (ready_now[(idx - 1) % MaskW]) return idx;
      end
      return 0;
    endfunction

    function logic reschedule();
      int unsigned nxt;
      logic sw;
      nxt = pick_next();
      sw = (nxt != running) || !has_run_any;
      running = nxt;
      has_run_any = 1;
      return sw;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [TicksW-1:0] ticks);
      int unsigned n;
      int unsigned s;
      pick_t p;
      n = live_threads();
      p = '0;
      case (op)
        OP_TICK: begin
          for (int k = 1; k < n; k++) begin
            s = (k - 1) % MaxThreads;
            if (sleep_left[s] != '0) begin
              sleep_left[s] = sleep_left[s] - 1'b1;
              if (sleep_left[s] == '0) ready_now[s] = 1'b1;
            end
          end
        end
        OP_DELAY: begin
          if (running == 0) begin
            p.err = 1'b1;
          end else begin
            s = (running - 1) % MaxThreads;
            sleep_left[s] = ticks;
            ready_now[s] = 1'b0;
            p.switch_req = reschedule();
          end
        end
        OP_SCHED: begin
          p.switch_req = reschedule();
        end
        default: ;
      endcase
      p.thread = ThreadW'(running);
      p.mask = ready_now;
      pending_picks.push_back(p);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_pick(pick_t got);
      pick_t want;
      if (pending_picks.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_picks.pop_front();
        if (got.thread !== want.thread)
          report($sformatf("next_thread %0d, want %0d", got.thread, want.thread));
        if (got.switch_req !== want.switch_req)
          report($sformatf("switch_request %0b, want %0b", got.switch_req, want.switch_req));
        if (got.mask !== want.mask)
          report($sformatf("ready_mask %h, want %h", got.mask, want.mask));
        if (got.err !== want.err)
          report($sformatf("error %0b, want %0b", got.err, want.err));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OpW-1:0]     opcode_i;
  logic [TicksW-1:0]  delay_ticks_i;
  logic               result_valid_o;
  logic [ThreadW-1:0] next_thread_o;
  logic               switch_request_o;
  logic [MaskW-1:0]   ready_mask_o;
  logic               error_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ThreadW-1:0] cfg_data_i;

  schedule_tracker tracker;
  bit              steady;

  round_robin_thread_scheduler dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .delay_ticks_i    (delay_ticks_i),
    .result_valid_o   (result_valid_o),
    .next_thread_o    (next_thread_o),
    .switch_request_o (switch_request_o),
    .ready_mask_o     (ready_mask_o),
    .error_o          (error_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pick_t got;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got.thread = next_thread_o;
      got.switch_req = switch_request_o;
      got.mask = ready_mask_o;
      got.err = error_o;
      tracker.check_pick(got);
    end
  end

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 11) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic send_request(logic [OpW-1:0] op, logic [TicksW-1:0] ticks);
    idle_gap();
    @(negedge clk_i);
    start <= 1'b1;
    opcode_i <= op;
    delay_ticks_i <= ticks;
    do @(posedge clk_i); while (busy);
    tracker.note_request(op, ticks);
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.pending_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_thread_total(logic [ThreadW-1:0] value);
    drain_requests();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_thread_total(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [OpW-1:0] random_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_TICK;
    if (r < 65) return OP_SCHED;
    if (r < 93) return OP_DELAY;
    return OpUnused;
  endfunction

  function automatic logic [TicksW-1:0] random_ticks();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 80) return TicksW'($urandom_range(6, 1));
    return $urandom();
  endfunction

  initial begin
    logic [ThreadW-1:0] phase_totals [10];
    tracker = new();
    steady = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = OP_TICK;
    delay_ticks_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // only the idle thread is registered
    send_request(OP_SCHED, '0);
    send_request(OP_DELAY, 32'd5);
    send_request(OP_TICK, '0);
    send_request(OpUnused, '1);
    send_request(OP_SCHED, '0);

    // one user thread: sleep, wake, and a zero-length sleep that never ends
    write_thread_total(ThreadW'(2));
    send_request(OP_SCHED, '0);
    send_request(OP_DELAY, 32'd1);
    send_request(OP_SCHED, '0);
    send_request(OP_TICK, '0);
    send_request(OP_SCHED, '0);
    send_request(OP_DELAY, '0);
    send_request(OP_TICK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_SCHED, '0);

    // full set of threads
    write_thread_total(ThreadW'(MaxThreads + 1));
    send_request(OP_SCHED, '0);
    send_request(OP_DELAY, '1);
    send_request(OP_DELAY, 32'd2);
    send_request(OP_SCHED, '0);
    send_request(OP_TICK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_SCHED, '0);
    send_request(OpUnused, 32'h8000_0000);

    phase_totals = '{6'd63, 6'd5, 6'd0, 6'd17, 6'd2, 6'd32, 6'd33, 6'd9, 6'd1, 6'd3};
    phase_totals[9] = ThreadW'($urandom_range(MaxThreads + 1, 1));
    for (int ph = 0; ph < 10; ph++) begin
      write_thread_total(phase_totals[ph]);
      steady = (ph == 3);
      send_request(OP_SCHED, '0);
      for (int i = 0; i < 74; i++) begin
        // hold off until every outstanding result is back
        if (ph == 1 && i == 40) drain_requests();
        send_request(random_op(), random_ticks());
      end
    end
    steady = 0;

    drain_requests();
    repeat (40) @(posedge clk_i);
    if (tracker.pending_picks.size() != 0) tracker.report("results still outstanding");
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
